>>> rtl/abkf_pkg.sv
// shared types, constants and the step microcode of the angle/bias kalman filter
// no dependencies; used by every module of the block
package abkf_pkg;

    localparam int DATA_W  = 32;
    localparam int CFG_W   = 31;
    localparam int IDX_W   = 2;
    localparam int PC_W    = 5;
    localparam int WIDE_W  = 66;
    localparam int DVD_W   = 57;
    localparam int DVS_W   = 33;
    localparam int MSN_W   = 48;
    localparam int MS_SHIFT = 36;

    localparam logic [IDX_W-1:0] REG_ANGLE_NOISE = 2'd0;
    localparam logic [IDX_W-1:0] REG_BIAS_NOISE  = 2'd1;
    localparam logic [IDX_W-1:0] REG_MEAS_NOISE  = 2'd2;

    localparam logic [CFG_W-1:0] ANGLE_NOISE_RST = 31'd16777;
    localparam logic [CFG_W-1:0] BIAS_NOISE_RST  = 31'd50332;
    localparam logic [CFG_W-1:0] MEAS_NOISE_RST  = 31'd8388608;
    localparam logic signed [DATA_W-1:0] ONE_Q24 = 32'sd16777216;
    localparam logic [9:0]  MS_PER_S = 10'd1000;
    // ceil(2^36 / 1000), exact quotient for any 26-bit dividend
    localparam logic [26:0] MS_RECIP = 27'd68719477;
    localparam logic [1:0]  MS_DIGIT_LAST = 2'd2;

    localparam logic [PC_W-1:0] PC_LAST = 5'd31;

    typedef struct packed {
        logic signed [31:0] gyro_rate;
        logic signed [31:0] accel_angle;
        logic [15:0]        step_ms;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] angle_estimate;
        logic signed [31:0] rate_corrected;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_DIFF,
        OP_PRED,
        OP_INNOV,
        OP_MUL,
        OP_DIV_MS,
        OP_DIV_GAIN,
        OP_ACC_Q,
        OP_ACC_ADD,
        OP_ACC_SUB,
        OP_SET_K
    } op_t;

    typedef enum logic [2:0] {
        OPD_T,
        OPD_U,
        OPD_QB,
        OPD_K0,
        OPD_K1,
        OPD_ERR,
        OPD_MS
    } opnd_t;

    typedef enum logic [2:0] {
        TGT_ANGLE,
        TGT_BIAS,
        TGT_AA,
        TGT_AB,
        TGT_BA,
        TGT_BB,
        TGT_K0,
        TGT_K1
    } tgt_t;

    typedef struct packed {
        op_t   op;
        opnd_t opa;
        opnd_t opb;
        tgt_t  tgt;
    } uop_t;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic out_load;
        uop_t uop;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } dp_stat_t;

    function automatic uop_t mk(op_t op, opnd_t a, opnd_t b, tgt_t t);
        uop_t u;
        u.op  = op;
        u.opa = a;
        u.opb = b;
        u.tgt = t;
        return u;
    endfunction

    // one filter step: predict, gains, correct, covariance update
    function automatic uop_t ucode(logic [PC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            5'd0:  u = mk(OP_DIFF,     OPD_T,  OPD_MS,  TGT_ANGLE);
            5'd1:  u = mk(OP_MUL,      OPD_T,  OPD_MS,  TGT_ANGLE);
            5'd2:  u = mk(OP_DIV_MS,   OPD_T,  OPD_MS,  TGT_ANGLE);
            5'd3:  u = mk(OP_ACC_Q,    OPD_T,  OPD_MS,  TGT_ANGLE);
            5'd4:  u = mk(OP_PRED,     OPD_T,  OPD_MS,  TGT_AA);
            5'd5:  u = mk(OP_MUL,      OPD_T,  OPD_MS,  TGT_AA);
            5'd6:  u = mk(OP_DIV_MS,   OPD_T,  OPD_MS,  TGT_AA);
            5'd7:  u = mk(OP_ACC_Q,    OPD_T,  OPD_MS,  TGT_AA);
            5'd8:  u = mk(OP_MUL,      OPD_U,  OPD_MS,  TGT_AB);
            5'd9:  u = mk(OP_DIV_MS,   OPD_U,  OPD_MS,  TGT_AB);
            5'd10: u = mk(OP_ACC_Q,    OPD_U,  OPD_MS,  TGT_AB);
            5'd11: u = mk(OP_ACC_Q,    OPD_U,  OPD_MS,  TGT_BA);
            5'd12: u = mk(OP_MUL,      OPD_QB, OPD_MS,  TGT_BB);
            5'd13: u = mk(OP_DIV_MS,   OPD_QB, OPD_MS,  TGT_BB);
            5'd14: u = mk(OP_ACC_Q,    OPD_QB, OPD_MS,  TGT_BB);
            5'd15: u = mk(OP_INNOV,    OPD_T,  OPD_MS,  TGT_AA);
            5'd16: u = mk(OP_DIV_GAIN, OPD_T,  OPD_MS,  TGT_K0);
            5'd17: u = mk(OP_SET_K,    OPD_T,  OPD_MS,  TGT_K0);
            5'd18: u = mk(OP_DIV_GAIN, OPD_U,  OPD_MS,  TGT_K1);
            5'd19: u = mk(OP_SET_K,    OPD_U,  OPD_MS,  TGT_K1);
            5'd20: u = mk(OP_MUL,      OPD_K0, OPD_ERR, TGT_ANGLE);
            5'd21: u = mk(OP_ACC_ADD,  OPD_K0, OPD_ERR, TGT_ANGLE);
            5'd22: u = mk(OP_MUL,      OPD_K1, OPD_ERR, TGT_BIAS);
            5'd23: u = mk(OP_ACC_ADD,  OPD_K1, OPD_ERR, TGT_BIAS);
            5'd24: u = mk(OP_MUL,      OPD_K0, OPD_T,   TGT_AA);
            5'd25: u = mk(OP_ACC_SUB,  OPD_K0, OPD_T,   TGT_AA);
            5'd26: u = mk(OP_MUL,      OPD_K0, OPD_U,   TGT_AB);
            5'd27: u = mk(OP_ACC_SUB,  OPD_K0, OPD_U,   TGT_AB);
            5'd28: u = mk(OP_MUL,      OPD_K1, OPD_T,   TGT_BA);
            5'd29: u = mk(OP_ACC_SUB,  OPD_K1, OPD_T,   TGT_BA);
            5'd30: u = mk(OP_MUL,      OPD_K1, OPD_U,   TGT_BB);
            5'd31: u = mk(OP_ACC_SUB,  OPD_K1, OPD_U,   TGT_BB);
            default: u = mk(OP_DIFF,   OPD_T,  OPD_MS,  TGT_ANGLE);
        endcase
        return u;
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        logic signed [WIDE_W-1:0] lo;
        hi = WIDE_W'(32'sh7fffffff);
        lo = WIDE_W'(32'sh80000000);
        if (v > hi) begin
            return 32'sh7fffffff;
        end else if (v < lo) begin
            return 32'sh80000000;
        end else begin
            return v[DATA_W-1:0];
        end
    endfunction

endpackage

>>> rtl/abkf_div.sv
// shared signed divider, one quotient bit per cycle, quotient truncated toward zero
// depends on abkf_pkg
module abkf_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic signed [abkf_pkg::DVD_W-1:0] dividend,
    input  logic signed [abkf_pkg::DVS_W-1:0] divisor,
    output logic signed [abkf_pkg::DVD_W-1:0] quotient,
    output logic                             done
);
    import abkf_pkg::*;

    localparam int MAG_W  = DVD_W - 1;
    localparam int DMAG_W = DVS_W - 1;
    localparam int CNT_W  = $clog2(MAG_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAG_W - 1);

    logic [MAG_W-1:0]  quo_reg, quo_next;
    logic [DMAG_W:0]   rem_reg, rem_next;
    logic [DMAG_W-1:0] dvs_reg;
    logic              neg_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg, done_reg;

    logic signed [DVD_W-1:0] dvd_abs;
    logic signed [DVS_W-1:0] dvs_abs;
    logic [DMAG_W:0]         rem_sh;
    logic                    ge;

    assign dvd_abs = dividend[DVD_W-1] ? -dividend : dividend;
    assign dvs_abs = divisor[DVS_W-1]  ? -divisor  : divisor;

    always_comb begin
        rem_sh   = {rem_reg[DMAG_W-1:0], quo_reg[MAG_W-1]};
        ge       = rem_sh >= {1'b0, dvs_reg};
        rem_next = ge ? rem_sh - {1'b0, dvs_reg} : rem_sh;
        quo_next = {quo_reg[MAG_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dvd_abs[MAG_W-1:0];
            rem_reg <= '0;
            dvs_reg <= dvs_abs[DMAG_W-1:0];
            neg_reg <= dividend[DVD_W-1] ^ divisor[DVS_W-1];
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign done     = done_reg;

endmodule

>>> rtl/abkf_ctrl.sv
// step sequencer: walks the microcode and waits on the gain divider, the divide-by-1000 unit and the output register
// depends on abkf_pkg
module abkf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  abkf_pkg::dp_stat_t  stat,
    output abkf_pkg::dp_cmd_t   cmd
);
    import abkf_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_RUN  = 4'b0010,
        ST_WAIT = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    uop_t            uop;

    assign uop = ucode(pc_reg);

    always_comb begin
        state_next   = state_reg;
        pc_next      = pc_reg;
        s_ready      = 1'b0;
        cmd.load_in  = 1'b0;
        cmd.exec     = 1'b0;
        cmd.out_load = 1'b0;
        cmd.uop      = uop;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    pc_next     = '0;
                    state_next  = ST_RUN;
                end
            end
            ST_RUN: begin
                cmd.exec = 1'b1;
                if (uop.op == OP_DIV_MS || uop.op == OP_DIV_GAIN) begin
                    state_next = ST_WAIT;
                end else if (pc_reg == PC_LAST) begin
                    state_next = ST_DONE;
                end else begin
                    pc_next = pc_reg + 1'b1;
                end
            end
            ST_WAIT: begin
                if (stat.div_done) begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

endmodule

>>> rtl/abkf_dp.sv
// filter datapath: state, config registers, one multiplier, gain divider, divide-by-1000
// unit, output register; depends on abkf_pkg and abkf_div
module abkf_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [abkf_pkg::IDX_W-1:0]    cfg_index,
    input  logic [abkf_pkg::CFG_W-1:0]    cfg_wdata,
    input  abkf_pkg::in_item_t            s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output abkf_pkg::out_item_t           m_data,
    input  abkf_pkg::dp_cmd_t             cmd,
    output abkf_pkg::dp_stat_t            stat
);
    import abkf_pkg::*;

    logic [CFG_W-1:0] qa_reg, qb_reg, r_reg;

    logic signed [DATA_W-1:0] gyro_reg, accel_reg;
    logic [15:0]              ms_reg;

    logic signed [DATA_W-1:0] angle_reg, bias_reg;
    logic signed [DATA_W-1:0] aa_reg, ab_reg, ba_reg, bb_reg;
    logic signed [DATA_W-1:0] t_reg, u_reg, e_reg, err_reg, k0_reg, k1_reg;
    logic signed [63:0]       prod_reg;

    out_item_t out_reg;
    logic      out_valid_reg;

    logic signed [DATA_W-1:0] opa_val, opb_val, base_val, wb_next;
    logic signed [WIDE_W-1:0] rnd_val;
    logic signed [DVD_W-1:0]  div_dvd, div_quot;
    logic signed [DVS_W-1:0]  div_dvs;
    logic                     div_start, div_done;

    logic [MSN_W-1:0]         msn_reg, msq_reg;
    logic [9:0]               msr_reg;
    logic [15:0]              msd_reg;
    logic [1:0]               msc_reg;
    logic                     msph_reg, msbusy_reg, msdone_reg, msneg_reg;
    logic signed [63:0]       prod_neg;
    logic [MSN_W-1:0]         ms_mag;
    logic [25:0]              ms_cur, ms_rem_full;
    logic [52:0]              ms_prod;
    logic signed [MSN_W:0]    ms_quot;
    logic                     ms_start;

    function automatic logic signed [DATA_W-1:0] pick(
        opnd_t                    sel,
        logic signed [DATA_W-1:0] t,
        logic signed [DATA_W-1:0] u,
        logic signed [DATA_W-1:0] qb,
        logic signed [DATA_W-1:0] k0,
        logic signed [DATA_W-1:0] k1,
        logic signed [DATA_W-1:0] err,
        logic signed [DATA_W-1:0] ms
    );
        case (sel)
            OPD_T:   return t;
            OPD_U:   return u;
            OPD_QB:  return qb;
            OPD_K0:  return k0;
            OPD_K1:  return k1;
            OPD_ERR: return err;
            OPD_MS:  return ms;
            default: return t;
        endcase
    endfunction

    assign opa_val = pick(cmd.uop.opa, t_reg, u_reg, $signed({1'b0, qb_reg}), k0_reg, k1_reg,
                          err_reg, $signed({16'b0, ms_reg}));
    assign opb_val = pick(cmd.uop.opb, t_reg, u_reg, $signed({1'b0, qb_reg}), k0_reg, k1_reg,
                          err_reg, $signed({16'b0, ms_reg}));

    // round to nearest of product / 2^24, ties toward +inf
    assign rnd_val = (WIDE_W'(prod_reg) + WIDE_W'(64'sd8388608)) >>> 24;

    always_comb begin
        case (cmd.uop.tgt)
            TGT_ANGLE: base_val = angle_reg;
            TGT_BIAS:  base_val = bias_reg;
            TGT_AA:    base_val = aa_reg;
            TGT_AB:    base_val = ab_reg;
            TGT_BA:    base_val = ba_reg;
            TGT_BB:    base_val = bb_reg;
            TGT_K0:    base_val = k0_reg;
            TGT_K1:    base_val = k1_reg;
            default:   base_val = angle_reg;
        endcase
        case (cmd.uop.op)
            OP_ACC_Q:   wb_next = sat32(WIDE_W'(base_val) + WIDE_W'(ms_quot));
            OP_ACC_ADD: wb_next = sat32(WIDE_W'(base_val) + rnd_val);
            OP_ACC_SUB: wb_next = sat32(WIDE_W'(base_val) - rnd_val);
            OP_SET_K:   wb_next = (e_reg == '0) ? '0 : sat32(WIDE_W'(div_quot));
            default:    wb_next = base_val;
        endcase
    end

    assign div_start = cmd.exec && (cmd.uop.op == OP_DIV_GAIN);
    assign div_dvd   = DVD_W'($signed({opa_val, 24'b0}));
    assign div_dvs   = DVS_W'(e_reg);

    abkf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .quotient (div_quot),
        .done     (div_done)
    );

    // divide by 1000: three 16-bit digits msb first, quotient digit by reciprocal
    // multiply registered first, remainder in the next cycle
    assign prod_neg    = -prod_reg;
    assign ms_mag      = prod_reg[63] ? prod_neg[MSN_W-1:0] : prod_reg[MSN_W-1:0];
    assign ms_cur      = {msr_reg, msn_reg[MSN_W-1 -: 16]};
    assign ms_prod     = 53'(ms_cur) * 53'(MS_RECIP);
    assign ms_rem_full = ms_cur - 26'(msd_reg) * 26'(MS_PER_S);
    assign ms_quot     = msneg_reg ? -$signed({1'b0, msq_reg}) : $signed({1'b0, msq_reg});
    assign ms_start    = cmd.exec && (cmd.uop.op == OP_DIV_MS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msbusy_reg <= 1'b0;
            msdone_reg <= 1'b0;
            msph_reg   <= 1'b0;
            msc_reg    <= '0;
        end else begin
            msdone_reg <= 1'b0;
            if (ms_start) begin
                msbusy_reg <= 1'b1;
                msph_reg   <= 1'b0;
                msc_reg    <= '0;
            end else if (msbusy_reg) begin
                msph_reg <= !msph_reg;
                if (msph_reg) begin
                    msc_reg <= msc_reg + 1'b1;
                    if (msc_reg == MS_DIGIT_LAST) begin
                        msbusy_reg <= 1'b0;
                        msdone_reg <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ms_start) begin
            msn_reg   <= ms_mag;
            msr_reg   <= '0;
            msneg_reg <= prod_reg[63];
        end else if (msbusy_reg) begin
            if (!msph_reg) begin
                msd_reg <= ms_prod[MS_SHIFT+15:MS_SHIFT];
            end else begin
                msr_reg <= ms_rem_full[9:0];
                msq_reg <= {msq_reg[MSN_W-17:0], msd_reg};
                msn_reg <= {msn_reg[MSN_W-17:0], 16'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qa_reg <= ANGLE_NOISE_RST;
            qb_reg <= BIAS_NOISE_RST;
            r_reg  <= MEAS_NOISE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ANGLE_NOISE: qa_reg <= cfg_wdata;
                REG_BIAS_NOISE:  qb_reg <= cfg_wdata;
                REG_MEAS_NOISE:  r_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            gyro_reg  <= s_data.gyro_rate;
            accel_reg <= s_data.accel_angle;
            ms_reg    <= s_data.step_ms;
        end
        if (cmd.exec) begin
            case (cmd.uop.op)
                OP_DIFF: t_reg <= sat32(WIDE_W'(gyro_reg) - WIDE_W'(bias_reg));
                OP_PRED: begin
                    t_reg <= sat32(WIDE_W'($signed({1'b0, qa_reg})) - WIDE_W'(ab_reg)
                                   - WIDE_W'(ba_reg));
                    u_reg <= sat32(-WIDE_W'(bb_reg));
                end
                OP_INNOV: begin
                    e_reg   <= sat32(WIDE_W'($signed({1'b0, r_reg})) + WIDE_W'(aa_reg));
                    err_reg <= sat32(WIDE_W'(accel_reg) - WIDE_W'(angle_reg));
                    t_reg   <= aa_reg;
                    u_reg   <= ab_reg;
                end
                OP_MUL: prod_reg <= opa_val * opb_val;
                default: ;
            endcase
        end
    end

    // state write-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg <= '0;
            bias_reg  <= '0;
            aa_reg    <= ONE_Q24;
            ab_reg    <= '0;
            ba_reg    <= '0;
            bb_reg    <= ONE_Q24;
            k0_reg    <= '0;
            k1_reg    <= '0;
        end else if (cmd.exec && (cmd.uop.op == OP_ACC_Q || cmd.uop.op == OP_ACC_ADD ||
                                  cmd.uop.op == OP_ACC_SUB || cmd.uop.op == OP_SET_K)) begin
            case (cmd.uop.tgt)
                TGT_ANGLE: angle_reg <= wb_next;
                TGT_BIAS:  bias_reg  <= wb_next;
                TGT_AA:    aa_reg    <= wb_next;
                TGT_AB:    ab_reg    <= wb_next;
                TGT_BA:    ba_reg    <= wb_next;
                TGT_BB:    bb_reg    <= wb_next;
                TGT_K0:    k0_reg    <= wb_next;
                TGT_K1:    k1_reg    <= wb_next;
                default: ;
            endcase
        end
    end

    // output register, holds a finished beat while the next step runs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.angle_estimate <= angle_reg;
            out_reg.rate_corrected <= sat32(WIDE_W'(gyro_reg) - WIDE_W'(bias_reg));
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_data        = out_reg;
    assign stat.div_done = div_done || msdone_reg;
    assign stat.out_free = !out_valid_reg || m_ready;

endmodule

>>> rtl/angle_bias_kalman_filter.sv
// Two-state kalman filter fusing gyro rate and accelerometer angle (angle and gyro bias).
// Input beat: gyro_rate, accel_angle (signed Q16.16) and step_ms. Output beat:
// angle_estimate and rate_corrected (signed Q16.16), one per input beat, in order.
// Configuration: cfg_we/cfg_index/cfg_wdata write the angle process noise (0), bias
// process noise (1) and measurement noise (2), unsigned Q7.24; other indexes are ignored.
// Write them only while no step is in flight.
// One step at a time: the next input beat is accepted only after the previous step ends.
// The radix-2 gain divider takes most of the step time with its two divisions. The four
// divisions by 1000 for the step time (three 16-bit digits by reciprocal multiply) add to
// it, as do 26 multiply and add steps and the load of the output register.
// s_ready is high only between steps. A finished beat sits in the output register; the
// next step starts at once and only stalls at its end if that beat has not been taken.
// Reset (aresetn low, synchronous) clears angle and bias, sets the covariance to identity
// and reloads the default noise values.
// depends on abkf_pkg, abkf_ctrl, abkf_dp
module angle_bias_kalman_filter (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [abkf_pkg::IDX_W-1:0]  cfg_index,
    input  logic [abkf_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  abkf_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output abkf_pkg::out_item_t         m_data
);
    import abkf_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    abkf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    abkf_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
